/* src/dsl_pkg.sv */
// Shared types and constants for the deceleration speed limiter.
// No dependencies; imported by deceleration_speed_limiter_top.
package dsl_pkg;

  // Pose status code forced when the target counts as reached
  localparam logic [2:0] STATUS_REACHED = 3'd1;

  // Configuration register indexes
  localparam logic CFG_STOP_THRESHOLD = 1'b0;
  localparam logic CFG_DECELERATION   = 1'b1;

  localparam logic [30:0] CFG_DECEL_RESET = 31'd65536;
  localparam logic [30:0] SPEED_MAX       = 31'h7FFF_FFFF;

  // One result bit per square-root stage (64-bit radicand)
  localparam int SQRT_STEPS = 32;

  // Fields that ride along the pipeline unchanged
  typedef struct packed {
    logic [32:0] err;
    logic [31:0] vcur;
    logic [30:0] base;     // speed when no ramp applies
    logic [2:0]  status;
    logic        reached;
  } carry_t;

  // Square-root stage payload
  typedef struct packed {
    logic [63:0] x;        // radicand bits not yet consumed, MSB first
    logic [33:0] r;        // partial remainder
    logic [31:0] q;        // partial root
    logic        ramp;
    carry_t      c;
  } sq_t;

endpackage

/* src/deceleration_speed_limiter_top.sv */
// Deceleration speed limiter: error, stopping-distance test and ramp speed.
// Depends on dsl_pkg (types, codes, constants).
// Pipeline: 36 register stages (stage 1, stage 2, sq_q[0] to sq_q[32] and
//   the output register).
// Throughput: one item per cycle without output stalls; every stage holds
//   its own valid bit, so bubbles fill while the output register is stalled.
// Reset: rst_ni async low clears all valid bits and loads the register
//   defaults (stop_threshold 0, deceleration 1.0 in Q16.16).
module deceleration_speed_limiter_top import dsl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] current_pose_i,
  input  logic signed [31:0] target_pose_i,
  input  logic signed [31:0] current_speed_i,
  input  logic signed [31:0] target_speed_i,
  input  logic [2:0]         status_in_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [32:0] pos_err_o,
  output logic signed [31:0] speed_passthrough_o,
  output logic [30:0]        limited_speed_o,
  output logic               limit_disabled_o,
  output logic [2:0]         status_out_o
);

  // ---------------------------------------------------------------------
  // Configuration registers. Writes must only arrive while the block is idle;
  // the block itself does not enforce this. The stages read them live.
  // ---------------------------------------------------------------------
  logic [30:0] cfg_thr_q;
  logic [30:0] cfg_decel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_thr_q   <= '0;
      cfg_decel_q <= CFG_DECEL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STOP_THRESHOLD: cfg_thr_q   <= cfg_data_i;
        CFG_DECELERATION:   cfg_decel_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Per-stage enables: a stage loads when it is empty or its successor
  // loads. The chain is one bit wide.
  // ---------------------------------------------------------------------
  logic                  s1_v_q, s2_v_q, out_v_q;
  logic [SQRT_STEPS:0]   sq_v_q;
  logic                  s1_en, s2_en, out_en;
  logic [SQRT_STEPS:0]   sq_en;

  assign out_en = !out_v_q || !out_stall_i;
  assign sq_en[SQRT_STEPS] = !sq_v_q[SQRT_STEPS] || out_en;
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_en
    assign sq_en[k] = !sq_v_q[k] || sq_en[k+1];
  end
  assign s2_en = !s2_v_q || sq_en[0];
  assign s1_en = !s1_v_q || s2_en;
  assign in_stall_o = !s1_en;

  // ---------------------------------------------------------------------
  // Stage 1: error, magnitudes, threshold test, fallback speed.
  // ---------------------------------------------------------------------
  logic signed [32:0] err_d;
  logic [32:0]        aerr_full;
  logic [31:0]        aerr_d, avreq_d, av_d;
  logic               reached_d;
  carry_t             s1_c_d;

  always_comb begin
    err_d     = 33'(target_pose_i) - 33'(current_pose_i);
    aerr_full = err_d[32] ? 33'(-err_d) : 33'(err_d);
    aerr_d    = aerr_full[31:0];           // |err| <= 2^32-1
    avreq_d   = target_speed_i[31]  ? 32'(-target_speed_i)  : 32'(target_speed_i);
    av_d      = current_speed_i[31] ? 32'(-current_speed_i) : 32'(current_speed_i);
    reached_d = aerr_d <= {1'b0, cfg_thr_q};
    s1_c_d.err     = err_d;
    s1_c_d.vcur    = current_speed_i;
    s1_c_d.reached = reached_d;
    s1_c_d.status  = reached_d ? STATUS_REACHED : status_in_i;
    if (reached_d) begin
      s1_c_d.base = '0;
    end else begin
      s1_c_d.base = avreq_d[31] ? SPEED_MAX : avreq_d[30:0];
    end
  end

  carry_t      s1_c_q;
  logic [31:0] s1_aerr_q, s1_av_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_c_q    <= s1_c_d;
      s1_aerr_q <= aerr_d;
      s1_av_q   <= av_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the two products, 2*D*E and V*V (both fit 64 bits).
  // ---------------------------------------------------------------------
  logic [62:0] de_prod;
  logic [63:0] vsq_d;

  assign de_prod = 63'(cfg_decel_q) * 63'(s1_aerr_q);
  assign vsq_d   = 64'(s1_av_q) * 64'(s1_av_q);

  carry_t      s2_c_q;
  logic [63:0] s2_lhs_q, s2_vsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) begin
      s2_c_q   <= s1_c_q;
      s2_lhs_q <= {de_prod, 1'b0};
      s2_vsq_q <= vsq_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3 (sq_q[0]): stopping-distance compare, seed the square root.
  // ---------------------------------------------------------------------
  sq_t sq_q [SQRT_STEPS+1];
  sq_t sq0_d;

  always_comb begin
    sq0_d.x    = s2_lhs_q;
    sq0_d.r    = '0;
    sq0_d.q    = '0;
    sq0_d.ramp = !s2_c_q.reached && (s2_lhs_q <= s2_vsq_q);
    sq0_d.c    = s2_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (sq_en[0]) begin
      sq_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_en[0] && s2_v_q) begin
      sq_q[0] <= sq0_d;
    end
  end

  // ---------------------------------------------------------------------
  // Square root: one root bit per stage, two radicand bits consumed.
  // Before step k the root has k bits and r <= 2q < 2^32, so the shift
  // of r below is lossless.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [33:0] r_sh, trial, r_sub;
    logic        fits;
    sq_t         step_d;

    always_comb begin
      r_sh  = {sq_q[k].r[31:0], sq_q[k].x[63:62]};
      trial = {sq_q[k].q, 2'b01};
      r_sub = r_sh - trial;
      fits  = r_sh >= trial;
      step_d      = sq_q[k];
      step_d.x    = {sq_q[k].x[61:0], 2'b00};
      step_d.r    = fits ? r_sub : r_sh;
      step_d.q    = {sq_q[k].q[30:0], fits};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (sq_en[k+1]) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (sq_en[k+1] && sq_v_q[k]) begin
        sq_q[k+1] <= step_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: pick ramp speed (saturated) or the fallback.
  // ---------------------------------------------------------------------
  sq_t         fin;
  logic [30:0] speed_d;

  assign fin     = sq_q[SQRT_STEPS];
  assign speed_d = !fin.ramp   ? fin.c.base :
                   fin.q[31]   ? SPEED_MAX  : fin.q[30:0];

  logic [32:0] out_err_q;
  logic [31:0] out_vcur_q;
  logic [30:0] out_speed_q;
  logic [2:0]  out_status_q;
  logic        out_reached_q, out_ramp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= sq_v_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && sq_v_q[SQRT_STEPS]) begin
      out_err_q     <= fin.c.err;
      out_vcur_q    <= fin.c.vcur;
      out_speed_q   <= speed_d;
      out_status_q  <= fin.c.status;
      out_reached_q <= fin.c.reached;
      out_ramp_q    <= fin.ramp;
    end
  end

  assign out_valid_o         = out_v_q;
  assign pos_err_o           = out_err_q;
  assign speed_passthrough_o = out_vcur_q;
  assign limited_speed_o     = out_speed_q;
  assign limit_disabled_o    = 1'b0;
  assign status_out_o        = out_status_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // An empty output register must leave the whole pipe free to move.
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> !in_stall_o)
    else $error("input stalled while output register empty");

  // Input back-pressure only originates from a stalled, full output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_v_q && out_stall_i))
    else $error("input stalled without output back-pressure");

  // A reached item never takes the ramp path and reports zero speed.
  a_reached_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_reached_q) |->
      (!out_ramp_q && out_speed_q == '0 && out_status_q == STATUS_REACHED))
    else $error("reached item with nonzero speed or ramp");

endmodule

/* verif/tb.sv */
// Self-checking testbench for deceleration_speed_limiter_top.
// Depends on dsl_pkg and the RTL top; a predictor computes each expected item
// and a monitor compares every output item with the oldest expectation.
module tb;
  import dsl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run limits.
  localparam int LIMIT_CYCLES = 500_000;
  localparam int END_SETTLE   = 40;    // settle time before the verdict, longer than the pipeline latency
  localparam int HOLD_AT      = 600;   // output count at which the long back-pressure starts
  localparam int HOLD_CYCLES  = 300;   // long enough to fill the whole pipeline
  localparam int MAX_PRINTS   = 100;

  // One input item, fields kept as raw two's complement bits
  typedef struct packed {
    logic [31:0] cur;
    logic [31:0] tgt;
    logic [31:0] vcur;
    logic [31:0] vreq;
    logic [2:0]  status;
  } pose_item_t;

  // One output item
  typedef struct packed {
    logic [32:0] err;
    logic [31:0] vpass;
    logic [30:0] speed;
    logic        disabled;
    logic [2:0]  status;
  } limit_result_t;

  // DUT connections; every input starts at a known value
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = CFG_STOP_THRESHOLD;
  logic [30:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] current_pose_i = '0;
  logic signed [31:0] target_pose_i = '0;
  logic signed [31:0] current_speed_i = '0;
  logic signed [31:0] target_speed_i = '0;
  logic [2:0]         status_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [32:0] pos_err_o;
  logic signed [31:0] speed_passthrough_o;
  logic [30:0]        limited_speed_o;
  logic               limit_disabled_o;
  logic [2:0]         status_out_o;

  // Predictor copy of the two registers, reset values
  logic [30:0] stop_thr = '0;
  logic [30:0] decel = CFG_DECEL_RESET;

  pose_item_t    pose_backlog[$];      // items waiting to be offered
  limit_result_t expected_limits[$];   // predicted items, oldest first

  int idle_pct = 0;                    // per-cycle chance (percent) that an idle burst starts
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int n_results = 0;
  int n_errors = 0;
  int cycle_count = 0;

  deceleration_speed_limiter_top uut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
               expected_limits.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // |target - current|, exact in 33 bits
  function automatic logic [32:0] err_mag(input pose_item_t it);
    logic [32:0] e;
    e = {it.tgt[31], it.tgt} - {it.cur[31], it.cur};
    return e[32] ? -e : e;
  endfunction

  // 2*D*|e|: compared against v*v instead of dividing for the stopping distance
  function automatic logic [63:0] stop_radicand(input logic [32:0] mag);
    return (64'(decel) * 64'(mag)) << 1;
  endfunction

  // floor(sqrt(x)), one root bit at a time from the top
  function automatic logic [31:0] root_floor(input logic [63:0] x);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if (64'(t) * 64'(t) <= x) r = t;
    end
    return r;
  endfunction

  function automatic limit_result_t limit_speed(input pose_item_t it);
    limit_result_t r;
    logic [32:0] mag;
    logic [31:0] av;
    logic [31:0] areq;
    logic [63:0] spd;
    logic [63:0] lhs;
    mag  = err_mag(it);
    av   = it.vcur[31] ? -it.vcur : it.vcur;   // 0x8000_0000 stays 2^31
    areq = it.vreq[31] ? -it.vreq : it.vreq;
    spd  = 64'(areq);
    r.err      = {it.tgt[31], it.tgt} - {it.cur[31], it.cur};
    r.vpass    = it.vcur;
    r.disabled = 1'b0;
    r.status   = it.status;
    if (mag <= 33'(stop_thr)) begin
      // target reached: stop
      r.status = STATUS_REACHED;
      spd = '0;
    end else begin
      // not reached: ramp down when inside the stopping distance
      lhs = stop_radicand(mag);
      if (lhs <= 64'(av) * 64'(av)) spd = 64'(root_floor(lhs));
    end
    r.speed = (spd > 64'(SPEED_MAX)) ? SPEED_MAX : spd[30:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: offers the backlog, holds a stalled item, idles in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_limits.push_back(limit_speed(pose_backlog.pop_front()));
      end
      // Payload may only change when nothing is offered or the offer was taken
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 17);
          in_valid_i <= 1'b0;
        end else if (pose_backlog.size() != 0) begin
          in_valid_i      <= 1'b1;
          current_pose_i  <= pose_backlog[0].cur;
          target_pose_i   <= pose_backlog[0].tgt;
          current_speed_i <= pose_backlog[0].vcur;
          target_speed_i  <= pose_backlog[0].vreq;
          status_in_i     <= pose_backlog[0].status;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks accepted items, drives back-pressure
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_errors < MAX_PRINTS)
      $display("%0t ns item %0d: %s got %0h, want %0h", $realtime, n_results, field,
               got, want);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    limit_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_limits.size() == 0) begin
          report_mismatch("unexpected item, err", 64'(pos_err_o), '0);
        end else begin
          want = expected_limits.pop_front();
          if (pos_err_o !== want.err)
            report_mismatch("pos_err", 64'(pos_err_o), 64'(want.err));
          if (speed_passthrough_o !== want.vpass)
            report_mismatch("speed_passthrough", 64'(speed_passthrough_o), 64'(want.vpass));
          if (limited_speed_o !== want.speed)
            report_mismatch("limited_speed", 64'(limited_speed_o), 64'(want.speed));
          if (limit_disabled_o !== want.disabled)
            report_mismatch("limit_disabled", 64'(limit_disabled_o), 64'(want.disabled));
          if (status_out_o !== want.status)
            report_mismatch("status_out", 64'(status_out_o), 64'(want.status));
        end
        n_results++;
      end
      // Once, mid-run, hold the output long enough that the input backs up
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && n_results >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        recv_gap = $urandom_range(0, 17);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [31:0] cur, input logic [31:0] tgt,
                           input logic [31:0] vcur, input logic [31:0] vreq,
                           input logic [2:0] status);
    pose_backlog.push_back('{cur: cur, tgt: tgt, vcur: vcur, vreq: vreq, status: status});
  endtask

  // Block until every queued item went in and every prediction came back
  task automatic drain();
    while (pose_backlog.size() != 0 || expected_limits.size() != 0 || in_valid_i)
      @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == CFG_STOP_THRESHOLD) stop_thr = val;
    else decel = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random items, mostly aimed at the reach threshold and the ramp boundary
  task automatic queue_random(input int n);
    pose_item_t  it;
    logic [31:0] off;
    logic [31:0] v;
    logic [63:0] lhs;
    for (int i = 0; i < n; i++) begin
      it.cur    = $urandom;
      it.tgt    = $urandom;
      it.vcur   = $urandom;
      it.vreq   = $urandom;
      it.status = $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0, 1: begin
          // small error around zero
          it.tgt = it.cur + ($urandom_range(0, 8191) - 32'd4096);
        end
        2, 3: begin
          // error right at or just past the stop threshold
          it.cur = $urandom_range(0, 2097151) - 32'd1048576;
          off = 32'(stop_thr) + $urandom_range(0, 1);
          it.tgt = $urandom_range(0, 1) ? it.cur + off : it.cur - off;
        end
        4: begin
          // rail-to-rail poses
          it.cur = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          it.tgt = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        default: ;
      endcase
      if ($urandom_range(0, 1)) begin
        // measured speed right at the stopping-distance boundary
        lhs = stop_radicand(err_mag(it));
        v = root_floor(lhs);
        if ($urandom_range(0, 1) && 64'(v) * 64'(v) < lhs) v = v + 1;
        if (v <= 32'h8000_0000) it.vcur = $urandom_range(0, 1) ? -v : v;
      end
      if ($urandom_range(0, 31) == 0) it.vreq = 32'h8000_0000;
      if ($urandom_range(0, 31) == 0) it.vcur = 32'h8000_0000;
      pose_backlog.push_back(it);
    end
  endtask

  task automatic run_phase(input logic [30:0] thr, input logic [30:0] dec, input int n,
                           input int pct);
    write_reg(CFG_STOP_THRESHOLD, thr);
    write_reg(CFG_DECELERATION, dec);
    @(negedge clk_i);
    idle_pct = pct;
    queue_random(n);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items on reset registers: threshold 0, deceleration 1.0
    idle_pct = 5;
    push_item(32'h0, 32'h0, 32'h0, 32'h1234_5678, 3'd0);                  // zero error: reached
    push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    push_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 3'd0);  // max error, ramp
    push_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 3'd2);  // min error, ramp
    push_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 3'd3);  // speed saturates
    push_item(32'h0, 32'h10_0000, 32'h0, 32'h7FFF_FFFF, 3'd4);            // no ramp, max speed
    push_item(32'h0, 32'h1, 32'h0, 32'h0001_0000, 3'd5);                  // error one LSB
    push_item(32'h1, 32'h0, 32'h0, 32'hFFFF_0000, 3'd6);                  // error minus one
    push_item(32'h0, 32'h1, 32'd362, 32'h7FFF_0000, 3'd0);                // just outside ramp
    push_item(32'h0, 32'h1, 32'd363, 32'h7FFF_0000, 3'd1);                // just inside ramp
    push_item(32'h0, 32'h2, 32'd512, 32'h7FFF_0000, 3'd0);                // 2DE == V*V
    push_item(32'h0, 32'hFFFF_FFFE, 32'hFFFF_FE00, 32'h7FFF_0000, 3'd1);  // same, negative
    push_item(32'h0, 32'h2, 32'd511, 32'h7FFF_0000, 3'd2);                // one below
    push_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 3'd5);
    push_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 3'd2);
    push_item(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 3'd1);          // reached, extremes
    push_item(32'h1_0000, 32'h0, 32'h7FFF_FFFF, 32'h1, 3'd0);             // ramp at one unit
    drain();

    // Threshold at its maximum, deceleration at its minimum
    run_phase(SPEED_MAX, 31'd1, 400, 8);
    // No threshold, steepest deceleration; the long output hold lands here
    run_phase('0, SPEED_MAX, 400, 4);
    // Random register settings
    run_phase(31'($urandom_range(0, 65535)), 31'($urandom_range(1, 1 << 24)), 200, 6);
    run_phase(31'($urandom), 31'($urandom | 1), 200, 3);
    // Last stretch: reset deceleration, no idling on either side
    run_phase(31'($urandom_range(0, 1023)), CFG_DECEL_RESET, 400, 0);

    repeat (END_SETTLE) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dsl_pkg.sv
src/deceleration_speed_limiter_top.sv
verif/tb.sv
